// ----- sv/wvm_pkg.sv -----
`timescale 1ns / 1ps

package wvm_pkg;

	localparam int DAC_W     = 12;
	localparam int DAC_MAX   = 4095;
	localparam int DAC_MID   = 2048;
	localparam int FRAC_BITS = 16;
	localparam int MIX_SHIFT = 10;
	localparam int VOL_SHIFT = 4;
	localparam int STEP_W    = 24;
	localparam int WORD_W    = 16;
	localparam int VOL_W     = 8;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_VOICE = 2'd1;
	localparam logic [1:0] OP_TABLE = 2'd2;

	typedef struct packed {
		logic shift;
		logic load;
	} wvm_cell_ctrl_t;

	typedef struct packed {
		logic clr;
		logic vld;
		logic act;
		logic last;
	} wvm_mix_ctrl_t;

endpackage

// ----- sv/wvm_cell.sv -----
`timescale 1ns / 1ps

module wvm_cell #(
	parameter int PH_W = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wvm_pkg::wvm_cell_ctrl_t    ctrl,
	input  logic                       ld_act,
	input  logic [PH_W-1:0]            ld_step,
	input  logic [wvm_pkg::VOL_W-1:0]  ld_vol,
	input  logic [PH_W-1:0]            nb_phase,
	input  logic [PH_W-1:0]            nb_step,
	input  logic [wvm_pkg::VOL_W-1:0]  nb_vol,
	input  logic                       nb_act,
	output logic [PH_W-1:0]            phase,
	output logic [PH_W-1:0]            step,
	output logic [wvm_pkg::VOL_W-1:0]  vol,
	output logic                       act
);

	logic [PH_W-1:0]           phase_q;
	logic [PH_W-1:0]           step_q;
	logic [wvm_pkg::VOL_W-1:0] vol_q;
	logic                      act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			step_q  <= '0;
			vol_q   <= '0;
			act_q   <= 1'b0;
		end else if (ctrl.shift) begin
			phase_q <= nb_phase;
			step_q  <= nb_step;
			vol_q   <= nb_vol;
			act_q   <= nb_act;
		end else if (ctrl.load) begin
			step_q  <= ld_step;
			vol_q   <= ld_vol;
			act_q   <= ld_act;
		end
	end

	assign phase = phase_q;
	assign step  = step_q;
	assign vol   = vol_q;
	assign act   = act_q;

endmodule

// ----- sv/wvm_table.sv -----
`timescale 1ns / 1ps

module wvm_table #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [$clog2(TABLE_DEPTH)-1:0]       wa,
	input  logic signed [wvm_pkg::WORD_W-1:0]    wd,
	input  logic                                 re,
	input  logic [$clog2(TABLE_DEPTH)-1:0]       ra,
	output logic signed [wvm_pkg::WORD_W-1:0]    rd
);

	logic signed [wvm_pkg::WORD_W-1:0] mem [TABLE_DEPTH];
	logic signed [wvm_pkg::WORD_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= mem[ra];
		end
	end

	assign rd = rd_q;

endmodule

// ----- sv/wvm_mix.sv -----
`timescale 1ns / 1ps

module wvm_mix #(
	parameter int NUM_VOICES = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  wvm_pkg::wvm_mix_ctrl_t             ctrl,
	input  logic signed [wvm_pkg::WORD_W-1:0]  word,
	input  logic [wvm_pkg::VOL_W-1:0]          vol,
	output logic                               done,
	output logic [wvm_pkg::DAC_W-1:0]          level
);

	localparam int PROD_W = wvm_pkg::WORD_W + wvm_pkg::VOL_W + 1;
	localparam int TERM_W = PROD_W - wvm_pkg::VOL_SHIFT;
	localparam int ACC_W  = TERM_W + $clog2(NUM_VOICES) + 1;
	localparam int SH_W   = ACC_W - wvm_pkg::MIX_SHIFT;
	localparam int LV_W   = SH_W + 1;

	logic signed [PROD_W-1:0] prod;
	logic signed [TERM_W-1:0] term_s2;
	logic                     vld_s2;
	logic                     last_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     done_q;
	logic signed [SH_W-1:0]   sh;
	logic signed [LV_W-1:0]   lv;

	assign prod = word * $signed({1'b0, vol});

	always_ff @(posedge clk) begin
		term_s2 <= ctrl.act ? prod[PROD_W-1:wvm_pkg::VOL_SHIFT] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
			done_q  <= 1'b0;
			acc_q   <= '0;
		end else begin
			vld_s2  <= ctrl.vld;
			last_s2 <= ctrl.vld && ctrl.last;
			done_q  <= vld_s2 && last_s2;
			if (ctrl.clr) begin
				acc_q <= '0;
			end else if (vld_s2) begin
				acc_q <= acc_q + ACC_W'(term_s2);
			end
		end
	end

	// floor shift of the sum, then offset and clamp
	assign sh = acc_q[ACC_W-1:wvm_pkg::MIX_SHIFT];
	assign lv = LV_W'(sh) + LV_W'(wvm_pkg::DAC_MID);

	always_comb begin
		if (lv < 0) begin
			level = '0;
		end else if (lv > LV_W'(wvm_pkg::DAC_MAX)) begin
			level = wvm_pkg::DAC_W'(wvm_pkg::DAC_MAX);
		end else begin
			level = lv[wvm_pkg::DAC_W-1:0];
		end
	end

	assign done = done_q;

endmodule

// ----- sv/wavetable_voice_mixer_top.sv -----
`timescale 1ns / 1ps

// Wavetable voice mixer.
// Item channel (item_valid/item_ready): op selects a sample tick, a voice
// update or a table write. Sample channel (sample_valid/sample_ready): one
// 12-bit offset-binary beat per tick, nothing for other items.
// Voice state sits in a ring of NUM_VOICES cells. A tick rotates the ring
// once round; each cycle the voice leaving the head advances its phase,
// addresses the single read port of the wave table and re-enters the tail.
// Table words are scaled and summed over two further stages.
// After a tick is accepted, item_ready stays low while the ring rotates, the
// last scaled words are summed and the beat waits to enter the output
// register; the ring rotation through the one table port sets how often
// ticks can be taken. Voice and table items are written without leaving idle.
// Reset clears all voices to silent with zero phase, step and volume; the
// table holds nothing until written.
// A beat waiting on a stalled receiver is held in the output register while
// further voice and table items are taken; a following tick completes its
// pass and then waits until the register is free.
module wavetable_voice_mixer_top #(
	parameter int NUM_VOICES  = 16,
	parameter int TABLE_DEPTH = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  logic [1:0]                         op,
	input  logic [3:0]                         voice_index,
	input  logic                               voice_enable,
	input  logic [wvm_pkg::STEP_W-1:0]         phase_step,
	input  logic [wvm_pkg::VOL_W-1:0]          volume,
	input  logic [7:0]                         table_index,
	input  logic signed [wvm_pkg::WORD_W-1:0]  table_value,
	output logic                               sample_valid,
	input  logic                               sample_ready,
	output logic [wvm_pkg::DAC_W-1:0]          dac_sample
);

	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int PH_W  = AW + wvm_pkg::FRAC_BITS;
	localparam int CW    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int RED_N = (PH_W >= 25) ? 0 : 25 - PH_W;
	localparam int RW    = ((PH_W > 25) ? PH_W : 25) + 1;
	localparam logic [PH_W:0] SPAN = (PH_W + 1)'(TABLE_DEPTH * 65536);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_FLUSH = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t                            state_q;
	logic [CW-1:0]                     cnt_q;
	logic                              beat_in;
	logic                              start;
	logic                              voice_wr;
	logic                              table_wr;
	logic                              rotate;
	logic                              last;
	logic                              load_out;
	logic [RW-1:0]                     red;
	logic [PH_W-1:0]                   st_red;
	logic [PH_W:0]                     ph_sum;
	logic [PH_W:0]                     ph_wrap;
	logic [PH_W-1:0]                   head_ph;
	logic [PH_W-1:0]                   ph_c  [NUM_VOICES];
	logic [PH_W-1:0]                   st_c  [NUM_VOICES];
	logic [wvm_pkg::VOL_W-1:0]         vol_c [NUM_VOICES];
	logic                              act_c [NUM_VOICES];
	logic                              vld_s1;
	logic                              last_s1;
	logic                              act_s1;
	logic [wvm_pkg::VOL_W-1:0]         vol_s1;
	logic signed [wvm_pkg::WORD_W-1:0] word_s1;
	wvm_pkg::wvm_mix_ctrl_t            mix_ctrl;
	logic                              mix_done;
	logic [wvm_pkg::DAC_W-1:0]         mix_level;
	logic                              out_valid_q;
	logic [wvm_pkg::DAC_W-1:0]         dac_q;

	assign item_ready = (state_q == ST_IDLE);
	assign beat_in    = item_valid && item_ready;
	assign start      = beat_in && (op == wvm_pkg::OP_TICK);
	assign voice_wr   = beat_in && (op == wvm_pkg::OP_VOICE) &&
	                    (32'(voice_index) < NUM_VOICES);
	assign table_wr   = beat_in && (op == wvm_pkg::OP_TABLE) &&
	                    (32'(table_index) < TABLE_DEPTH);
	assign rotate     = (state_q == ST_RUN);
	assign last       = (cnt_q == CW'(NUM_VOICES - 1));

	// step reduced modulo the phase span, so a tick wraps at most once
	always_comb begin
		red = RW'(phase_step);
		for (int k = RED_N - 1; k >= 0; k--) begin
			if (red >= (RW'(SPAN) << k)) begin
				red = red - (RW'(SPAN) << k);
			end
		end
		st_red = red[PH_W-1:0];
	end

	assign ph_sum  = {1'b0, ph_c[0]} + {1'b0, st_c[0]};
	assign ph_wrap = (ph_sum >= SPAN) ? ph_sum - SPAN : ph_sum;
	assign head_ph = act_c[0] ? ph_wrap[PH_W-1:0] : ph_c[0];

	for (genvar i = 0; i < NUM_VOICES; i++) begin : g_cell
		logic [PH_W-1:0]           nph;
		logic [PH_W-1:0]           nst;
		logic [wvm_pkg::VOL_W-1:0] nvol;
		logic                      nact;
		wvm_pkg::wvm_cell_ctrl_t   cc;

		if (i == NUM_VOICES - 1) begin : g_tail
			assign nph  = head_ph;
			assign nst  = st_c[0];
			assign nvol = vol_c[0];
			assign nact = act_c[0];
		end else begin : g_body
			assign nph  = ph_c[i+1];
			assign nst  = st_c[i+1];
			assign nvol = vol_c[i+1];
			assign nact = act_c[i+1];
		end

		assign cc.shift = rotate;
		assign cc.load  = voice_wr && (32'(voice_index) == i);

		wvm_cell #(
			.PH_W(PH_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cc),
			.ld_act   (voice_enable),
			.ld_step  (st_red),
			.ld_vol   (volume),
			.nb_phase (nph),
			.nb_step  (nst),
			.nb_vol   (nvol),
			.nb_act   (nact),
			.phase    (ph_c[i]),
			.step     (st_c[i]),
			.vol      (vol_c[i]),
			.act      (act_c[i])
		);
	end

	wvm_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk (clk),
		.we  (table_wr),
		.wa  (AW'(table_index)),
		.wd  (table_value),
		.re  (rotate),
		.ra  (head_ph[PH_W-1:wvm_pkg::FRAC_BITS]),
		.rd  (word_s1)
	);

	always_ff @(posedge clk) begin
		vol_s1 <= vol_c[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			act_s1  <= 1'b0;
		end else begin
			vld_s1  <= rotate;
			last_s1 <= rotate && last;
			act_s1  <= rotate && act_c[0];
		end
	end

	assign mix_ctrl.clr  = start;
	assign mix_ctrl.vld  = vld_s1;
	assign mix_ctrl.act  = act_s1;
	assign mix_ctrl.last = last_s1;

	wvm_mix #(
		.NUM_VOICES(NUM_VOICES)
	) u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mix_ctrl),
		.word   (word_s1),
		.vol    (vol_s1),
		.done   (mix_done),
		.level  (mix_level)
	);

	assign load_out = (state_q == ST_EMIT) && (!out_valid_q || sample_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					cnt_q <= CW'(cnt_q + 1'b1);
					if (last) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (mix_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (sample_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			dac_q <= mix_level;
		end
	end

	assign sample_valid = out_valid_q;
	assign dac_sample   = dac_q;

	a_done_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		mix_done |-> state_q == ST_FLUSH)
		else $error("mix completion outside flush");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !vld_s1 && !mix_ctrl.last)
		else $error("table pipeline busy while idle");

	a_beat_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sample_valid) |-> $past(state_q == ST_EMIT))
		else $error("sample beat raised outside emit");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	localparam int         VOICES         = 16;
	localparam int         DEPTH          = 256;
	localparam logic [1:0] OP_SPARE       = 2'd3;
	localparam int         WATCHDOG_LIMIT = 3000;
	localparam int         HOLD_CYCLES    = 400;
	localparam int         DRAIN_CYCLES   = 2 * (VOICES + 5);

	typedef struct {
		logic [1:0]                        op;
		logic [3:0]                        vi;
		logic                              en;
		logic [wvm_pkg::STEP_W-1:0]        step;
		logic [wvm_pkg::VOL_W-1:0]         gain;
		logic [7:0]                        ti;
		logic signed [wvm_pkg::WORD_W-1:0] word;
	} mix_item_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              item_valid = 1'b0;
	logic                              item_ready;
	logic [1:0]                        op = wvm_pkg::OP_TICK;
	logic [3:0]                        voice_index = '0;
	logic                              voice_enable = 1'b0;
	logic [wvm_pkg::STEP_W-1:0]        phase_step = '0;
	logic [wvm_pkg::VOL_W-1:0]         volume = '0;
	logic [7:0]                        table_index = '0;
	logic signed [wvm_pkg::WORD_W-1:0] table_value = '0;
	logic                              sample_valid;
	logic                              sample_ready = 1'b0;
	logic [wvm_pkg::DAC_W-1:0]         dac_sample;

	// predicted synthesiser state
	logic signed [wvm_pkg::WORD_W-1:0] wave_words [DEPTH];
	bit                                word_loaded [DEPTH];
	logic [wvm_pkg::STEP_W-1:0]        voice_phase [VOICES];
	logic [wvm_pkg::STEP_W-1:0]        voice_step [VOICES];
	logic [wvm_pkg::VOL_W-1:0]         voice_gain [VOICES];
	bit                                voice_on [VOICES];

	logic [wvm_pkg::DAC_W-1:0] pending_samples [$];
	int                        fail_count = 0;
	int                        send_idle_pct = 0;
	int                        recv_idle_pct = 0;
	bit                        hold_req = 1'b0;
	bit                        hold_seen = 1'b0;
	int                        hold_left = 0;
	int                        quiet_cycles = 0;

	wavetable_voice_mixer_top #(
		.NUM_VOICES (VOICES),
		.TABLE_DEPTH(DEPTH)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.op          (op),
		.voice_index (voice_index),
		.voice_enable(voice_enable),
		.phase_step  (phase_step),
		.volume      (volume),
		.table_index (table_index),
		.table_value (table_value),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.dac_sample  (dac_sample)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [wvm_pkg::DAC_W-1:0] mix_next_sample();
		int                         acc;
		int                         level;
		int                         word;
		int                         gain;
		logic [wvm_pkg::STEP_W-1:0] nxt;
		logic [7:0]                 idx;
		acc = 0;
		for (int v = 0; v < VOICES; v++) begin
			if (voice_on[v]) begin
				nxt = voice_phase[v] + voice_step[v];
				voice_phase[v] = nxt;
				idx = nxt[wvm_pkg::STEP_W-1:wvm_pkg::FRAC_BITS];
				word = wave_words[idx];
				gain = voice_gain[v];
				acc += (word * gain) >>> wvm_pkg::VOL_SHIFT;
			end
		end
		level = (acc >>> wvm_pkg::MIX_SHIFT) + wvm_pkg::DAC_MID;
		if (level > wvm_pkg::DAC_MAX)
			level = wvm_pkg::DAC_MAX;
		else if (level < 0)
			level = 0;
		return level[wvm_pkg::DAC_W-1:0];
	endfunction

	function automatic void apply_item(mix_item_t it);
		case (it.op)
			wvm_pkg::OP_TICK: begin
				pending_samples.push_back(mix_next_sample());
			end
			wvm_pkg::OP_VOICE: begin
				voice_on[it.vi]   = it.en;
				voice_step[it.vi] = it.step;
				voice_gain[it.vi] = it.gain;
			end
			wvm_pkg::OP_TABLE: begin
				wave_words[it.ti]  = it.word;
				word_loaded[it.ti] = 1'b1;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic mix_item_t random_item();
		mix_item_t it;
		it.op   = 2'($urandom());
		it.vi   = 4'($urandom());
		it.en   = 1'($urandom());
		it.step = wvm_pkg::STEP_W'($urandom());
		it.gain = wvm_pkg::VOL_W'($urandom());
		it.ti   = 8'($urandom());
		it.word = wvm_pkg::WORD_W'($urandom());
		return it;
	endfunction

	function automatic logic signed [wvm_pkg::WORD_W-1:0] pick_word();
		case ($urandom_range(0, 3))
			0:       return 16'sh7FFF;
			1:       return -16'sh8000;
			2:       return wvm_pkg::WORD_W'($urandom_range(0, 511)) - 16'sd256;
			default: return wvm_pkg::WORD_W'($urandom());
		endcase
	endfunction

	function automatic logic [wvm_pkg::STEP_W-1:0] pick_step();
		case ($urandom_range(0, 4))
			0:       return wvm_pkg::STEP_W'($urandom_range(0, 16'hFFFF));
			1:       return {8'($urandom()), 16'h0000};
			2:       return {wvm_pkg::STEP_W{1'b1}};
			3:       return '0;
			default: return wvm_pkg::STEP_W'($urandom());
		endcase
	endfunction

	function automatic logic [wvm_pkg::VOL_W-1:0] pick_gain();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return {wvm_pkg::VOL_W{1'b1}};
			default: return wvm_pkg::VOL_W'($urandom());
		endcase
	endfunction

	task automatic drive_item(mix_item_t it);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		op           = it.op;
		voice_index  = it.vi;
		voice_enable = it.en;
		phase_step   = it.step;
		volume       = it.gain;
		table_index  = it.ti;
		table_value  = it.word;
		item_valid   = 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		apply_item(it);
	endtask

	task automatic write_word(logic [7:0] ti, logic signed [wvm_pkg::WORD_W-1:0] word);
		mix_item_t it;
		it      = random_item();
		it.op   = wvm_pkg::OP_TABLE;
		it.ti   = ti;
		it.word = word;
		drive_item(it);
	endtask

	task automatic set_voice(logic [3:0] vi, logic en, logic [wvm_pkg::STEP_W-1:0] step,
			logic [wvm_pkg::VOL_W-1:0] gain);
		mix_item_t it;
		it      = random_item();
		it.op   = wvm_pkg::OP_VOICE;
		it.vi   = vi;
		it.en   = en;
		it.step = step;
		it.gain = gain;
		drive_item(it);
	endtask

	// loads any table word the coming tick would read before it is written
	task automatic send_tick();
		mix_item_t                  it;
		logic [wvm_pkg::STEP_W-1:0] nxt;
		for (int v = 0; v < VOICES; v++) begin
			if (voice_on[v]) begin
				nxt = voice_phase[v] + voice_step[v];
				if (!word_loaded[nxt[wvm_pkg::STEP_W-1:wvm_pkg::FRAC_BITS]])
					write_word(nxt[wvm_pkg::STEP_W-1:wvm_pkg::FRAC_BITS], pick_word());
			end
		end
		it    = random_item();
		it.op = wvm_pkg::OP_TICK;
		drive_item(it);
	endtask

	task automatic test_silent_tick();
		mix_item_t it;
		send_tick();
		it    = random_item();
		it.op = OP_SPARE;
		drive_item(it);
	endtask

	task automatic test_table_ends();
		write_word(8'd0, pick_word());
		write_word(8'd255, pick_word());
		write_word(8'd1, 16'sh7FFF);
		write_word(8'd2, -16'sh8000);
	endtask

	task automatic test_clamp();
		for (int v = 0; v < 5; v++)
			set_voice(4'(v), 1'b1, 24'h010000, 8'hFF);
		send_tick();
		send_tick();
	endtask

	task automatic test_phase_wrap();
		set_voice(4'd0, 1'b1, 24'hFFFFFF, 8'hFF);
		set_voice(4'd1, 1'b1, 24'h010000, 8'h00);
		set_voice(4'd2, 1'b0, 24'h010000, 8'hFF);
		set_voice(4'd15, 1'b1, 24'h000000, 8'h80);
		send_tick();
	endtask

	task automatic test_backpressure();
		hold_req = ~hold_req;
		repeat (12)
			send_tick();
	endtask

	task automatic test_random_traffic(int count);
		mix_item_t it;
		int        pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_tick();
			end else if (pick < 70) begin
				set_voice(4'($urandom()), $urandom_range(0, 99) < 75, pick_step(), pick_gain());
			end else if (pick < 95) begin
				write_word(8'($urandom()), pick_word());
			end else begin
				it    = random_item();
				it.op = OP_SPARE;
				drive_item(it);
			end
		end
	endtask

	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			sample_ready = 1'b0;
			hold_left--;
		end else begin
			sample_ready = ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		logic [wvm_pkg::DAC_W-1:0] want;
		if (arst_n && sample_valid && sample_ready) begin
			if (pending_samples.size() == 0) begin
				$error("dac_sample: expected none, actual %0d", dac_sample);
				fail_count++;
			end else begin
				want = pending_samples.pop_front();
				if (dac_sample !== want) begin
					$error("dac_sample: expected %0d, actual %0d", want, dac_sample);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (sample_valid && sample_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		for (int v = 0; v < VOICES; v++) begin
			voice_phase[v] = '0;
			voice_step[v]  = '0;
			voice_gain[v]  = '0;
			voice_on[v]    = 1'b0;
		end
		for (int i = 0; i < DEPTH; i++) begin
			wave_words[i]  = '0;
			word_loaded[i] = 1'b0;
		end
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 25;
		recv_idle_pct = 45;
		test_silent_tick();
		test_table_ends();
		test_clamp();
		test_phase_wrap();
		test_random_traffic(150);

		send_idle_pct = 45;
		recv_idle_pct = 25;
		test_random_traffic(150);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_backpressure();
		test_random_traffic(150);

		@(negedge clk);
		item_valid = 1'b0;
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- files.f -----
sv/wvm_pkg.sv
sv/wvm_cell.sv
sv/wvm_table.sv
sv/wvm_mix.sv
sv/wavetable_voice_mixer_top.sv
tb/testbench.sv
